// ===== rtl/btc_pkg.sv =====
// Shared types, constants and helper functions of the binary template classifier.
package btc_pkg;

    localparam int TEMPLATE_COUNT = 12;
    localparam int IMAGE_PIXELS   = 76800;

    localparam int SLOT_W   = 4;
    localparam int ADDR_W   = 17;
    localparam int THR_W    = 7;
    localparam int CNT_W    = 17;
    localparam int CLASS_W  = 4;

    localparam int MEM_AW     = $clog2(IMAGE_PIXELS);
    localparam int SLOT_IDX_W = (TEMPLATE_COUNT > 1) ? $clog2(TEMPLATE_COUNT) : 1;

    localparam int PERCENT_FULL = 100;
    localparam int SCALE        = 200;

    localparam int LIMIT_W = $clog2(PERCENT_FULL * IMAGE_PIXELS + 1);
    localparam int PROD_W  = CNT_W + $clog2(SCALE + 1);
    localparam int CMP_W   = (PROD_W > LIMIT_W) ? PROD_W : LIMIT_W;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [1:0] {
        CMD_LOAD_BIT = 2'd0,
        CMD_LOAD_THR = 2'd1,
        CMD_CLASSIFY = 2'd2
    } cmd_t;

    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [LIMIT_W-1:0] limit_t;

    typedef struct packed {
        logic [CLASS_W-1:0] symbol_class;
        logic               match_found;
        logic [CNT_W-1:0]   mismatch_count;
    } result_t;

    typedef struct packed {
        logic                  wr_en;
        logic                  rd_en;
        logic [MEM_AW-1:0]     addr;
        logic [SLOT_IDX_W-1:0] slot;
        logic                  wr_bit;
    } tmem_req_t;

    // Threshold that each slot holds after reset.
    function automatic logic [THR_W-1:0] thr_reset(input int k);
        logic [THR_W-1:0] thr;
        unique case (k)
            0:       thr = THR_W'(87);
            1:       thr = THR_W'(85);
            9:       thr = THR_W'(70);
            10:      thr = THR_W'(60);
            default: thr = THR_W'(75);
        endcase
        return thr;
    endfunction

    // A template passes when SCALE * mismatches is below this limit.
    function automatic limit_t limit_of(input logic [THR_W-1:0] thr);
        logic [THR_W-1:0] margin;
        margin = THR_W'(PERCENT_FULL) - thr;
        return LIMIT_W'(margin * IMAGE_PIXELS);
    endfunction

endpackage

// ===== rtl/binary_template_classifier_unit.sv =====
// Top level of the binary template classifier.
//
// Requests enter on the s_ group, one per clock while s_tready is high. s_tuser
// carries the command (load template bit, load threshold, classify pixel) and
// s_tlast marks the last classify pixel of an image. Load requests write the
// template store or the threshold of one slot and give no result. Every classify
// pixel updates the mismatch counters of all templates in parallel; the last one
// of an image yields one result on the m_ group: the first passing template
// number and its mismatch count, with match_found in m_tuser.
// Throughput is one request per cycle while s_tready is high. The result of the
// last pixel passes these registered steps: template store read, then counter
// update and snapshot, then the decision into the queue.
// Results wait in a four-entry queue; while the receiver stalls, requests are
// still taken, and s_tready drops only when queued plus in-flight results
// would fill it. Reset clears the counters, loads the default thresholds and
// empties the queue; template bits are undefined until written.
module binary_template_classifier_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // template_slot[3:0], pixel_address[20:4], pixel_bit[21],
    // threshold_percent[28:22], zero fill above
    input  logic [btc_pkg::IN_DATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [1:0]                     s_tuser,
    // last_pixel
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // symbol_class[3:0], mismatch_count[20:4], zero fill above
    output logic [btc_pkg::OUT_DATA_W-1:0] m_tdata,
    // match_found
    output logic                           m_tuser
);
    import btc_pkg::*;

    // Input field unpacking.
    cmd_t              in_cmd;
    logic [SLOT_W-1:0] in_slot;
    logic [ADDR_W-1:0] in_addr;
    logic              in_bit;
    logic [THR_W-1:0]  in_thr;
    logic              in_slot_ok;
    logic              in_addr_ok;
    logic              acc;

    assign in_cmd     = cmd_t'(s_tuser);
    assign in_slot    = s_tdata[3:0];
    assign in_addr    = s_tdata[20:4];
    assign in_bit     = s_tdata[21];
    assign in_thr     = s_tdata[28:22];
    assign in_slot_ok = 32'(in_slot) < TEMPLATE_COUNT;
    assign in_addr_ok = 32'(in_addr) < IMAGE_PIXELS;
    assign acc        = s_tvalid && s_tready;

    // Template store access happens in the accept cycle.
    tmem_req_t                 mem_req;
    logic [TEMPLATE_COUNT-1:0] mem_rd_data;

    assign mem_req.wr_en  = acc && (in_cmd == CMD_LOAD_BIT) && in_slot_ok && in_addr_ok;
    assign mem_req.rd_en  = acc && (in_cmd == CMD_CLASSIFY) && in_addr_ok;
    assign mem_req.addr   = in_addr[MEM_AW-1:0];
    assign mem_req.slot   = in_slot[SLOT_IDX_W-1:0];
    assign mem_req.wr_bit = in_bit;

    btc_tmem u_tmem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    // Stage 1 registers.
    logic                  s1_valid_reg;
    cmd_t                  s1_cmd_reg;
    logic [SLOT_IDX_W-1:0] s1_slot_reg;
    logic                  s1_slot_ok_reg;
    logic                  s1_addr_ok_reg;
    logic                  s1_bit_reg;
    logic [THR_W-1:0]      s1_thr_reg;
    logic                  s1_last_reg;

    logic s1_classify;
    logic s1_count;
    logic s1_finish;
    logic s1_thr_load;

    assign s1_classify = s1_valid_reg && (s1_cmd_reg == CMD_CLASSIFY);
    assign s1_count    = s1_classify && s1_addr_ok_reg;
    assign s1_finish   = s1_classify && s1_last_reg;
    assign s1_thr_load = s1_valid_reg && (s1_cmd_reg == CMD_LOAD_THR) && s1_slot_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            s1_cmd_reg     <= in_cmd;
            s1_slot_reg    <= in_slot[SLOT_IDX_W-1:0];
            s1_slot_ok_reg <= in_slot_ok;
            s1_addr_ok_reg <= in_addr_ok;
            s1_bit_reg     <= in_bit;
            s1_thr_reg     <= (in_thr > THR_W'(PERCENT_FULL)) ? THR_W'(PERCENT_FULL) : in_thr;
            s1_last_reg    <= s_tlast;
        end
    end

    // Stage 2: counter update, threshold write and end-of-image snapshot.
    cnt_t   cnt_reg      [TEMPLATE_COUNT];
    cnt_t   cnt_upd      [TEMPLATE_COUNT];
    cnt_t   cnt_next     [TEMPLATE_COUNT];
    limit_t lim_reg      [TEMPLATE_COUNT];
    cnt_t   snap_cnt_reg [TEMPLATE_COUNT];
    limit_t snap_lim_reg [TEMPLATE_COUNT];
    logic   snap_valid_reg;

    always_comb
    begin
        for (int k = 0; k < TEMPLATE_COUNT; k++)
        begin
            cnt_upd[k] = cnt_reg[k];
            if (s1_count && (mem_rd_data[k] ^ s1_bit_reg) && (cnt_reg[k] != CNT_MAX))
            begin
                cnt_upd[k] = cnt_reg[k] + CNT_W'(1);
            end
            cnt_next[k] = s1_finish ? '0 : cnt_upd[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < TEMPLATE_COUNT; k++)
            begin
                cnt_reg[k] <= '0;
                lim_reg[k] <= limit_of(thr_reset(k));
            end
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < TEMPLATE_COUNT; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
            if (s1_thr_load)
            begin
                lim_reg[s1_slot_reg] <= limit_of(s1_thr_reg);
            end
            snap_valid_reg <= s1_finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_finish)
        begin
            for (int k = 0; k < TEMPLATE_COUNT; k++)
            begin
                snap_cnt_reg[k] <= cnt_upd[k];
                snap_lim_reg[k] <= lim_reg[k];
            end
        end
    end

    // Stage 3: decision into the result queue.
    result_t decision;

    btc_decide u_decide (
        .cnt    (snap_cnt_reg),
        .lim    (snap_lim_reg),
        .result (decision)
    );

    result_t           q_reg [QDEPTH];
    logic [QPTR_W-1:0] q_wr_ptr_reg;
    logic [QPTR_W-1:0] q_rd_ptr_reg;
    logic [QCNT_W-1:0] q_count_reg;
    logic              q_push;
    logic              q_pop;
    logic [QCNT_W-1:0] occupancy;
    result_t           q_head;

    assign q_push = snap_valid_reg;
    assign q_pop  = m_tvalid && m_tready;

    // Count results already queued plus those still in the pipeline.
    assign occupancy = q_count_reg + QCNT_W'(s1_finish) + QCNT_W'(snap_valid_reg);
    assign s_tready  = occupancy < QCNT_W'(QDEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_wr_ptr_reg <= '0;
            q_rd_ptr_reg <= '0;
            q_count_reg  <= '0;
        end
        else
        begin
            if (q_push)
            begin
                q_wr_ptr_reg <= q_wr_ptr_reg + QPTR_W'(1);
            end
            if (q_pop)
            begin
                q_rd_ptr_reg <= q_rd_ptr_reg + QPTR_W'(1);
            end
            if (q_push && !q_pop)
            begin
                q_count_reg <= q_count_reg + QCNT_W'(1);
            end
            else if (q_pop && !q_push)
            begin
                q_count_reg <= q_count_reg - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_reg[q_wr_ptr_reg] <= decision;
        end
    end

    assign q_head   = q_reg[q_rd_ptr_reg];
    assign m_tvalid = q_count_reg != '0;
    assign m_tdata  = {(OUT_DATA_W - CNT_W - CLASS_W)'(0), q_head.mismatch_count,
                       q_head.symbol_class};
    assign m_tuser  = q_head.match_found;

    // An accepted last classify pixel reaches the snapshot stage via stage 1.
    a_finish_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && (in_cmd == CMD_CLASSIFY) && s_tlast) |-> ##2 snap_valid_reg)
        else $error("end-of-image request did not reach the decision stage");

    // The flow control must never let a result arrive at a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && (q_count_reg == QCNT_W'(QDEPTH))))
        else $error("result queue overflow");

    // A decided result is in the queue on the next cycle.
    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> (q_count_reg != '0))
        else $error("decided result not queued");

    // Counters restart from zero after the end of an image.
    a_counter_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s1_finish |=> (cnt_reg[0] == '0))
        else $error("mismatch counters not cleared after an image");

    // With no passing template the reported count is zero.
    a_zero_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (q_head.mismatch_count == '0))
        else $error("nonzero mismatch count without a match");

endmodule

// ===== rtl/btc_tmem.sv =====
// Template bit store: one word per pixel, one bit per template, registered read.
module btc_tmem (
    input  logic                                clk,
    input  btc_pkg::tmem_req_t                  req,
    output logic [btc_pkg::TEMPLATE_COUNT-1:0]  rd_data
);
    import btc_pkg::*;

    logic [TEMPLATE_COUNT-1:0] mem [IMAGE_PIXELS];
    logic [TEMPLATE_COUNT-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr][req.slot] <= req.wr_bit;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/btc_decide.sv =====
// End-of-image decision: tests every template and picks the first one that passes.
module btc_decide (
    input  btc_pkg::cnt_t    cnt [btc_pkg::TEMPLATE_COUNT],
    input  btc_pkg::limit_t  lim [btc_pkg::TEMPLATE_COUNT],
    output btc_pkg::result_t result
);
    import btc_pkg::*;

    logic [TEMPLATE_COUNT-1:0] pass;
    logic [TEMPLATE_COUNT-1:0] first;
    logic [CMP_W-1:0]          prod [TEMPLATE_COUNT];

    always_comb
    begin
        for (int k = 0; k < TEMPLATE_COUNT; k++)
        begin
            prod[k] = CMP_W'(cnt[k]) * CMP_W'(SCALE);
            pass[k] = prod[k] < CMP_W'(lim[k]);
        end
    end

    // Isolate the lowest passing template so the select below is a flat AND-OR.
    assign first = pass & (~pass + TEMPLATE_COUNT'(1));

    always_comb
    begin
        result = '0;
        for (int k = 0; k < TEMPLATE_COUNT; k++)
        begin
            if (first[k])
            begin
                result.symbol_class   = result.symbol_class | CLASS_W'(k + 1);
                result.match_found    = 1'b1;
                result.mismatch_count = result.mismatch_count | cnt[k];
            end
        end
    end

endmodule

// ===== test/binary_template_classifier_unit_test.sv =====
// Self-checking testbench for the binary template classifier top level.
module binary_template_classifier_unit_test;

    import btc_pkg::*;

    localparam int          CLK_HALF       = 5;
    localparam int          RESET_CYCLES   = 6;
    localparam int          IDLE_PERCENT   = 8;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          DRAIN_CYCLES   = 16;
    localparam int          CYCLE_LIMIT    = 2_000_000;
    localparam int          MAX_REPORTS    = 100;
    localparam int          POOL_SIZE      = 16;
    localparam int          RANDOM_ITEMS   = 1000;
    localparam int          MIN_VERDICTS   = 40;
    localparam int          BURST_IMAGES   = 40;
    localparam logic [1:0]  CMD_RESERVED   = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_TOP = '1;

    localparam logic [THR_W-1:0] DEFAULT_PERCENT [TEMPLATE_COUNT] =
        '{7'd87, 7'd85, 7'd75, 7'd75, 7'd75, 7'd75, 7'd75, 7'd75, 7'd75, 7'd70, 7'd60, 7'd75};

    typedef struct packed {
        logic [1:0]        cmd;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] addr;
        logic              pix;
        logic [THR_W-1:0]  thr;
        logic              last;
    } req_t;

    typedef struct {
        req_t        req;
        int unsigned reps;
        bit          typed;
        result_t     want;
    } step_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [1:0]            s_tuser = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    // Predictor state: template bits per address, mismatch counters, thresholds.
    logic [TEMPLATE_COUNT-1:0] template_bits [int];
    cnt_t                      diff_count [TEMPLATE_COUNT];
    logic [THR_W-1:0]          pass_percent [TEMPLATE_COUNT];
    logic [ADDR_W-1:0]         pixel_pool [POOL_SIZE];

    result_t     awaited_verdicts [$];
    step_t       script [$];
    int unsigned error_count = 0;
    int unsigned verdict_total = 0;
    int unsigned verdicts_checked = 0;
    int unsigned effective_items = 0;
    int unsigned cycle_count = 0;
    bit          idle_on = 1'b1;
    bit          hold_request = 1'b0;

    binary_template_classifier_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (error_count < MAX_REPORTS)
            $display("mismatch in result %0d: %s got %0d, expected %0d",
                     verdicts_checked, what, got, want);
        error_count++;
    endtask

    // Applies one accepted request to the predictor; returns 1 when it ends an image.
    function automatic bit track_request(input req_t r, output result_t verdict);
        logic [TEMPLATE_COUNT-1:0] word;
        bit                        addr_ok;
        bit                        slot_ok;
        bit                        found;
        verdict = '0;
        found   = 1'b0;
        addr_ok = r.addr < IMAGE_PIXELS;
        slot_ok = r.slot < TEMPLATE_COUNT;
        if (r.cmd == CMD_LOAD_BIT)
        begin
            if (slot_ok && addr_ok)
            begin
                word = template_bits.exists(int'(r.addr)) ? template_bits[int'(r.addr)] : '0;
                word[r.slot] = r.pix;
                template_bits[int'(r.addr)] = word;
            end
            return 1'b0;
        end
        if (r.cmd == CMD_LOAD_THR)
        begin
            if (slot_ok)
                pass_percent[r.slot] = (r.thr > PERCENT_FULL) ? THR_W'(PERCENT_FULL) : r.thr;
            return 1'b0;
        end
        if (r.cmd != CMD_CLASSIFY)
            return 1'b0;
        if (addr_ok)
        begin
            word = template_bits[int'(r.addr)];
            for (int k = 0; k < TEMPLATE_COUNT; k++)
                if ((word[k] ^ r.pix) && diff_count[k] != CNT_MAX)
                    diff_count[k]++;
        end
        if (!r.last)
            return 1'b0;
        for (int k = 0; k < TEMPLATE_COUNT; k++)
        begin
            if (!found && longint'(SCALE) * longint'(diff_count[k]) <
                longint'(PERCENT_FULL - int'(pass_percent[k])) * longint'(IMAGE_PIXELS))
            begin
                found                  = 1'b1;
                verdict.symbol_class   = CLASS_W'(k + 1);
                verdict.match_found    = 1'b1;
                verdict.mismatch_count = diff_count[k];
            end
        end
        foreach (diff_count[k])
            diff_count[k] = '0;
        return 1'b1;
    endfunction

    task automatic send_request(input req_t r, input bit use_typed, input result_t typed);
        result_t verdict;
        if (idle_on && $urandom_range(99) < IDLE_PERCENT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.cmd;
        s_tlast  <= r.last;
        s_tdata  <= IN_DATA_W'({r.thr, r.pix, r.addr, r.slot});
        do
            @(posedge clk);
        while (!s_tready);
        if (track_request(r, verdict))
        begin
            awaited_verdicts.push_back(use_typed ? typed : verdict);
            verdict_total++;
        end
        if (!(r.cmd == CMD_RESERVED || (r.cmd != CMD_CLASSIFY && r.slot >= TEMPLATE_COUNT)
              || (r.cmd == CMD_LOAD_BIT && r.addr >= IMAGE_PIXELS)))
            effective_items++;
    endtask

    function automatic void add_row(input logic [1:0] cmd, input int slot, input int addr,
                                    input bit pix, input int thr, input bit last,
                                    input int unsigned reps, input bit typed,
                                    input int cls, input bit found, input int cnt);
        step_t s;
        s.req   = '{cmd: cmd, slot: SLOT_W'(slot), addr: ADDR_W'(addr), pix: pix,
                    thr: THR_W'(thr), last: last};
        s.reps  = reps;
        s.typed = typed;
        s.want  = '{symbol_class: CLASS_W'(cls), match_found: found,
                    mismatch_count: CNT_W'(cnt)};
        script.push_back(s);
    endfunction

    // Loads, threshold writes and ignored requests that go between or into images.
    function automatic req_t random_side_request();
        req_t        r;
        int unsigned pick;
        int unsigned level;
        r.cmd  = CMD_LOAD_BIT;
        r.slot = SLOT_W'($urandom_range(0, TEMPLATE_COUNT - 1));
        r.addr = ADDR_W'($urandom);
        r.pix  = 1'($urandom);
        r.thr  = THR_W'($urandom);
        r.last = 1'($urandom);
        pick   = $urandom_range(0, 9);
        level  = $urandom_range(0, 7);
        if (pick <= 3)
            r.addr = pixel_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick == 4)
            r.addr = ADDR_W'($urandom_range(0, IMAGE_PIXELS - 1));
        else if (pick <= 6)
        begin
            r.cmd = CMD_LOAD_THR;
            // Mostly full or near-full thresholds, so that templates get skipped or fail.
            r.thr = (level < 4) ? THR_W'(PERCENT_FULL) :
                    (level < 6) ? THR_W'($urandom_range(97, 99)) : THR_W'($urandom);
        end
        else if (pick == 7)
            r.cmd = CMD_RESERVED;
        else if (pick == 8)
        begin
            if ($urandom_range(0, 1))
                r.slot = SLOT_W'($urandom_range(TEMPLATE_COUNT, 15));
            else
                r.addr = ADDR_W'($urandom_range(IMAGE_PIXELS, int'(ADDR_TOP)));
        end
        else
        begin
            r.cmd  = CMD_LOAD_THR;
            r.slot = SLOT_W'($urandom_range(TEMPLATE_COUNT, 15));
        end
        return r;
    endfunction

    // One camera image; pixels touch fully written pool addresses or out-of-range ones.
    task automatic send_image(input int unsigned len);
        req_t        r;
        int unsigned mode;
        mode = $urandom_range(0, 2);
        for (int unsigned n = 0; n < len; n++)
        begin
            if ($urandom_range(99) < 5)
                send_request(random_side_request(), 1'b0, '0);
            r.cmd  = CMD_CLASSIFY;
            r.slot = SLOT_W'($urandom);
            r.thr  = THR_W'($urandom);
            r.pix  = (mode == 0) ? 1'($urandom) : (mode == 2);
            r.last = (n == len - 1);
            if ($urandom_range(9) == 0)
                r.addr = ADDR_W'($urandom_range(IMAGE_PIXELS, int'(ADDR_TOP)));
            else
                r.addr = pixel_pool[$urandom_range(0, POOL_SIZE - 1)];
            send_request(r, 1'b0, '0);
        end
    endtask

    initial
    begin : result_sink
        int unsigned hold_left;
        result_t     want;
        logic        ready_next;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (awaited_verdicts.size() == 0)
                    report_mismatch("result with none awaited, class", m_tdata[3:0], 0);
                else
                begin
                    want = awaited_verdicts.pop_front();
                    if (m_tdata[3:0] != want.symbol_class)
                        report_mismatch("symbol_class", m_tdata[3:0], want.symbol_class);
                    if (m_tuser != want.match_found)
                        report_mismatch("match_found", m_tuser, want.match_found);
                    if (m_tdata[20:4] != want.mismatch_count)
                        report_mismatch("mismatch_count", m_tdata[20:4], want.mismatch_count);
                end
                verdicts_checked++;
            end
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (!rst_n)
                ready_next = 1'b0;
            else if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
                ready_next = !(idle_on && $urandom_range(99) < IDLE_PERCENT);
            m_tready <= ready_next;
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : stimulus
        req_t        r;
        int unsigned start_items;
        int unsigned start_verdicts;
        int unsigned image_no;
        foreach (pass_percent[k])
        begin
            pass_percent[k] = DEFAULT_PERCENT[k];
            diff_count[k]   = '0;
        end
        pixel_pool[0] = '0;
        pixel_pool[1] = ADDR_W'(IMAGE_PIXELS - 1);
        for (int p = 2; p < POOL_SIZE; p++)
            pixel_pool[p] = ADDR_W'($urandom_range(1, IMAGE_PIXELS - 2));

        // Address 0 holds all-zero templates and the top address all-one templates.
        add_row(CMD_CLASSIFY, 0, 0, 0, 0, 1, 1, 1, 1, 1, 0);
        add_row(CMD_LOAD_THR, 0, 0, 0, 127, 0, 1, 0, 0, 0, 0);
        add_row(CMD_LOAD_THR, 15, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(CMD_LOAD_THR, 12, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(CMD_CLASSIFY, 0, 0, 0, 0, 1, 1, 1, 2, 1, 0);
        add_row(CMD_LOAD_THR, 1, 0, 0, 99, 0, 1, 0, 0, 0, 0);
        // Just inside and just outside the 99 percent limit of the second template.
        add_row(CMD_CLASSIFY, 0, 0, 1, 0, 1, 383, 1, 2, 1, 383);
        add_row(CMD_CLASSIFY, 0, 0, 1, 0, 1, 384, 1, 3, 1, 384);
        add_row(CMD_LOAD_BIT, 12, 0, 1, 0, 0, 1, 0, 0, 0, 0);
        add_row(CMD_LOAD_BIT, 2, int'(ADDR_TOP), 1, 0, 0, 1, 0, 0, 0, 0);
        add_row(CMD_LOAD_BIT, 2, IMAGE_PIXELS, 1, 0, 0, 1, 0, 0, 0, 0);
        add_row(CMD_RESERVED, 0, 0, 1, 0, 1, 1, 0, 0, 0, 0);
        add_row(CMD_LOAD_BIT, 3, 0, 0, 0, 1, 1, 0, 0, 0, 0);
        add_row(CMD_LOAD_THR, 4, 0, 0, 75, 1, 1, 0, 0, 0, 0);
        add_row(CMD_CLASSIFY, 0, int'(ADDR_TOP), 1, 0, 1, 1, 1, 2, 1, 0);
        add_row(CMD_CLASSIFY, 0, IMAGE_PIXELS - 1, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(CMD_CLASSIFY, 0, IMAGE_PIXELS, 1, 0, 1, 1, 1, 2, 1, 1);
        add_row(CMD_LOAD_THR, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
        add_row(CMD_CLASSIFY, 0, IMAGE_PIXELS - 1, 1, 0, 1, 1, 1, 1, 1, 0);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every template bit of every pool address is written before any pixel reads it.
        foreach (pixel_pool[p])
        begin
            for (int k = 0; k < TEMPLATE_COUNT; k++)
            begin
                r = '{cmd: CMD_LOAD_BIT, slot: SLOT_W'(k), addr: pixel_pool[p],
                      pix: (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom),
                      thr: '0, last: 1'b0};
                send_request(r, 1'b0, '0);
            end
        end

        foreach (script[i])
        begin
            idle_on = (script[i].reps == 1);
            for (int unsigned n = 0; n < script[i].reps; n++)
            begin
                r      = script[i].req;
                r.last = script[i].req.last && (n == script[i].reps - 1);
                send_request(r, script[i].typed, script[i].want);
            end
        end

        // Short images while the receiver holds off, so the result queue fills up.
        idle_on        = 1'b1;
        start_items    = effective_items;
        start_verdicts = verdict_total;
        hold_request   = 1'b1;
        repeat (BURST_IMAGES) send_image(1);

        image_no = 0;
        while (effective_items - start_items < RANDOM_ITEMS ||
               verdict_total - start_verdicts < MIN_VERDICTS)
        begin
            idle_on = !(image_no >= 4 && image_no < 8);
            repeat ($urandom_range(0, 3)) send_request(random_side_request(), 1'b0, '0);
            if ($urandom_range(99) < 15)
                send_image($urandom_range(300, 700));
            else
                send_image($urandom_range(1, 40));
            image_no++;
        end
        s_tvalid <= 1'b0;
        idle_on = 1'b1;

        while (awaited_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
